/* design/sdp_pkg.sv */
// Shared types, codes and helpers for the step/direction pulse controller.
// Used by sdp_cfg, sdp_core and step_dir_pulse_controller; no dependencies.
package sdp_pkg;

    // Request codes
    localparam logic [2:0] REQ_TICK      = 3'd0;
    localparam logic [2:0] REQ_POWER_ON  = 3'd1;
    localparam logic [2:0] REQ_POWER_OFF = 3'd2;
    localparam logic [2:0] REQ_ALARM     = 3'd3;
    localparam logic [2:0] REQ_CLEAR     = 3'd4;
    localparam logic [2:0] REQ_SET_DIR   = 3'd5;
    localparam logic [2:0] REQ_RUN       = 3'd6;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ERR  = 2'd1;
    localparam logic [1:0] ST_BUSY = 2'd2;

    // Run completion codes
    localparam logic [1:0] FIN_NONE  = 2'd0;
    localparam logic [1:0] FIN_DONE  = 2'd1;
    localparam logic [1:0] FIN_ABORT = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_RISING    = 2'd0;
    localparam logic [1:0] CFG_FALLING   = 2'd1;
    localparam logic [1:0] CFG_POWER_OFF = 2'd2;
    localparam logic [1:0] CFG_FORWARD   = 2'd3;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_IDLE  = 2'd1,
        MODE_WORK  = 2'd2,
        MODE_ALARM = 2'd3
    } mode_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic        direction_forward;
        logic [31:0] step_count;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        power_level;
        logic        direction_level;
        logic        step_level;
        logic [1:0]  motor_mode;
        logic [31:0] steps_done;
        logic [1:0]  run_finished;
    } rsp_t;

    typedef struct packed {
        logic [15:0] rising_ticks;
        logic [15:0] falling_ticks;
        logic        power_off_level;
        logic        forward_level;
    } cfg_t;

    // A phase length of zero acts as one tick
    function automatic logic [15:0] ticks_or_one(input logic [15:0] t);
        ticks_or_one = (t == 16'd0) ? 16'd1 : t;
    endfunction

endpackage

/* design/sdp_cfg.sv */
// Configuration register bank: pulse timing and pin polarities.
// Depends on sdp_pkg.
module sdp_cfg
    import sdp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [15:0] wr_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rising_ticks    <= 16'd1;
            cfg_reg.falling_ticks   <= 16'd1;
            cfg_reg.power_off_level <= 1'b0;
            cfg_reg.forward_level   <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_RISING:    cfg_reg.rising_ticks    <= wr_data;
                CFG_FALLING:   cfg_reg.falling_ticks   <= wr_data;
                CFG_POWER_OFF: cfg_reg.power_off_level <= wr_data[0];
                CFG_FORWARD:   cfg_reg.forward_level   <= wr_data[0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/sdp_core.sv */
// Controller state and the single-pass update for one request.
// Depends on sdp_pkg; driven by the input stage of the top level.
module sdp_core
    import sdp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  req_t item,
    input  cfg_t cfg,
    output rsp_t result
);

    mode_t       mode_reg, mode_next;
    logic        running_reg, running_next;
    logic        power_reg, power_next;
    logic        dir_reg, dir_next;
    logic        step_reg, step_next;
    logic [15:0] timer_reg, timer_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] count_reg, count_next;

    always_comb
    begin
        logic [15:0] timer_dec;
        logic [1:0]  st;
        logic [1:0]  fin;

        mode_next    = mode_reg;
        running_next = running_reg;
        power_next   = power_reg;
        dir_next     = dir_reg;
        step_next    = step_reg;
        timer_next   = timer_reg;
        left_next    = left_reg;
        count_next   = count_reg;
        st           = ST_OK;
        fin          = FIN_NONE;
        timer_dec    = (timer_reg != 16'd0) ? timer_reg - 16'd1 : timer_reg;

        case (item.req_type)
            REQ_TICK:
            begin
                if (running_reg)
                begin
                    timer_next = timer_dec;
                    if (timer_dec == 16'd0)
                    begin
                        if (step_reg)
                        begin
                            step_next  = 1'b0;
                            timer_next = ticks_or_one(cfg.falling_ticks);
                        end
                        else
                        begin
                            // step boundary: count the pulse, then abort, finish or go on
                            count_next = count_reg + 32'd1;
                            left_next  = left_reg - 32'd1;
                            if (mode_reg == MODE_ALARM)
                            begin
                                running_next = 1'b0;
                                dir_next     = 1'b0;
                                left_next    = 32'd0;
                                st           = ST_ERR;
                                fin          = FIN_ABORT;
                            end
                            else if (left_reg == 32'd1)
                            begin
                                running_next = 1'b0;
                                mode_next    = MODE_IDLE;
                                fin          = FIN_DONE;
                            end
                            else
                            begin
                                step_next  = 1'b1;
                                timer_next = ticks_or_one(cfg.rising_ticks);
                            end
                        end
                    end
                end
            end
            REQ_ALARM:
            begin
                power_next = cfg.power_off_level;
                mode_next  = MODE_ALARM;
            end
            REQ_POWER_ON, REQ_POWER_OFF:
            begin
                if (running_reg)
                    st = ST_BUSY;
                else if (mode_reg == MODE_ALARM)
                    st = ST_ERR;
                else if (item.req_type == REQ_POWER_OFF)
                begin
                    mode_next  = MODE_OFF;
                    power_next = cfg.power_off_level;
                end
                else
                begin
                    mode_next  = MODE_IDLE;
                    power_next = ~cfg.power_off_level;
                end
            end
            REQ_CLEAR:
            begin
                if (running_reg)
                    st = ST_BUSY;
                else if (mode_reg == MODE_ALARM)
                    mode_next = MODE_IDLE;
            end
            REQ_SET_DIR:
            begin
                if (running_reg)
                    st = ST_BUSY;
                else if (mode_reg == MODE_ALARM)
                    st = ST_ERR;
                else
                    dir_next = item.direction_forward ? cfg.forward_level
                                                      : ~cfg.forward_level;
            end
            REQ_RUN:
            begin
                if (running_reg)
                    st = ST_BUSY;
                else if (mode_reg != MODE_IDLE)
                    st = ST_ERR;
                else
                begin
                    count_next = 32'd0;
                    if (item.step_count == 32'd0)
                        fin = FIN_DONE;
                    else
                    begin
                        mode_next    = MODE_WORK;
                        running_next = 1'b1;
                        left_next    = item.step_count;
                        step_next    = 1'b1;
                        timer_next   = ticks_or_one(cfg.rising_ticks);
                    end
                end
            end
            default:
                st = ST_ERR;
        endcase

        result.status          = st;
        result.power_level     = power_next;
        result.direction_level = dir_next;
        result.step_level      = step_next;
        result.motor_mode      = mode_next;
        result.steps_done      = count_next;
        result.run_finished    = fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_OFF;
            running_reg <= 1'b0;
            power_reg   <= 1'b0;
            dir_reg     <= 1'b0;
            step_reg    <= 1'b0;
            timer_reg   <= 16'd0;
            left_reg    <= 32'd0;
            count_reg   <= 32'd0;
        end
        else if (adv)
        begin
            mode_reg    <= mode_next;
            running_reg <= running_next;
            power_reg   <= power_next;
            dir_reg     <= dir_next;
            step_reg    <= step_next;
            timer_reg   <= timer_next;
            left_reg    <= left_next;
            count_reg   <= count_next;
        end
    end

`ifndef SYNTHESIS
    // A run always has at least one pulse outstanding
    a_run_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (left_reg != 32'd0))
        else $error("run active with no steps left");

    // The step pin is only high inside a run
    a_step_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg |-> running_reg)
        else $error("step pin high outside a run");

    // Working mode only exists while a run is active
    a_work_is_running: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_WORK) |-> running_reg)
        else $error("working mode without an active run");

    // A run in progress keeps its phase timer loaded
    a_timer_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (timer_reg != 16'd0))
        else $error("phase timer empty during a run");
`endif

endmodule

/* design/step_dir_pulse_controller.sv */
// Step/direction pulse controller for a stepper driver: top level.
// Requests (ticks or commands) enter on req, one result per request leaves on rsp.
// Configuration writes arrive on cfg; cfg_ready is always high.
// A request transfers when req_valid is high and req_stall is low; a result
// transfers when rsp_valid is high and rsp_stall is low.
// A transferred request sits in the input register, and its result is loaded into
// the result register when the request advances.
// Throughput: one request per cycle unless rsp_stall holds the result register; the
// controller state is updated in a single pass of logic from the input to the result register.
// When the receiver stalls, the result register holds its payload, and the input
// register holds one more request; req_stall rises only once both are full.
// Reset clears both register stages, puts the motor in the off mode with all pins
// low and loads rising_ticks = 1, falling_ticks = 1 and both polarities at 0.
// Depends on sdp_pkg, sdp_cfg and sdp_core.
module step_dir_pulse_controller
    import sdp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic in_valid_reg;
    req_t in_data_reg;
    logic out_valid_reg;
    rsp_t out_data_reg;
    logic out_free;
    logic adv;
    cfg_t cfg;
    rsp_t result;

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign adv       = in_valid_reg && out_free;
    assign req_stall = in_valid_reg && !out_free;
    assign cfg_ready = 1'b1;

    sdp_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    sdp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .item   (in_data_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!req_stall)
                in_valid_reg <= req_valid;
            if (out_free)
                out_valid_reg <= adv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
            in_data_reg <= req;
        if (adv)
            out_data_reg <= result;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

`ifndef SYNTHESIS
    // Every request processed shows up as a result on the next cycle
    a_adv_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_valid_reg)
        else $error("processed request produced no result");

    // The input stage only pushes back when the result stage is full and stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (out_valid_reg && rsp_stall && in_valid_reg))
        else $error("input stalled without a full, stalled output");

    // A held result must not be overwritten
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rsp_stall) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("stalled result changed");
`endif

endmodule
